// ===== rtl/core/nsfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsfm_pkg
// shared types, constants and float helpers of the nan-skipping float mean
// ----------------------------------------------------------------------------
package nsfm_pkg;

	localparam int COUNT_WIDTH_DEF = 24;
	localparam int VCOUNT_W        = 24;
	localparam int EXT_W           = 27;
	localparam int DIV_STEPS       = 26;
	localparam logic [31:0] QNAN   = 32'h7FC00000;
	localparam logic [30:0] INF_MAG = 31'h7F800000;

	typedef struct packed {
		logic [31:0] value_bits;
		logic        end_of_set;
	} sample_t;

	typedef struct packed {
		logic [31:0]         mean_bits;
		logic [VCOUNT_W-1:0] valid_count;
	} result_t;

	typedef struct packed {
		logic load;
		logic align;
		logic sum;
		logic norm;
		logic commit;
		logic cvt;
		logic crnd;
		logic dset;
		logic div_step;
		logic dfin;
		logic dpack;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic out_full;
	} stat_t;

	function automatic logic is_nan(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// right shift keeping everything shifted out in the sticky bit
	function automatic logic [EXT_W-1:0] shr_sticky(input logic [EXT_W-1:0] v,
			input logic [4:0] amt);
		logic [EXT_W-1:0] sh;
		logic [EXT_W-1:0] mask;
		logic lost;
		sh   = v >> amt;
		mask = ~({EXT_W{1'b1}} << amt);
		lost = |(v & mask);
		return {sh[EXT_W-1:1], sh[0] | lost};
	endfunction

	function automatic logic [4:0] lzc27(input logic [26:0] v);
		logic [4:0] n;
		logic found;
		n     = '0;
		found = 1'b0;
		for (int i = 26; i >= 0; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					n = n + 5'd1;
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc24(input logic [23:0] v);
		logic [4:0] n;
		logic found;
		n     = '0;
		found = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					n = n + 5'd1;
			end
		end
		return n;
	endfunction

	function automatic logic [4:0] lzc32(input logic [31:0] v);
		logic [4:0] n;
		logic found;
		n     = '0;
		found = 1'b0;
		for (int i = 31; i >= 1; i--) begin
			if (!found) begin
				if (v[i])
					found = 1'b1;
				else
					n = n + 5'd1;
			end
		end
		return n;
	endfunction

	// round to nearest even; a mantissa carry ripples into the exponent field
	function automatic logic [31:0] round_pack(input logic sign,
			input logic [EXT_W-1:0] ext, input logic [7:0] expf);
		logic inc;
		logic [30:0] mag;
		inc = ext[2] & (ext[1] | ext[0] | ext[3]);
		mag = {expf, ext[25:3]} + {30'd0, inc};
		return {sign, mag};
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/nsfm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsfm_ctrl
// sequencer: accumulate steps per item, convert and divide at end of set
// ----------------------------------------------------------------------------
module nsfm_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           sample_valid,
	output logic                sample_stall,
	input  wire nsfm_pkg::stat_t stat,
	output nsfm_pkg::cmd_t      cmd
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_ALIGN = 11'b000_0000_0010,
		ST_SUM   = 11'b000_0000_0100,
		ST_NORM  = 11'b000_0000_1000,
		ST_ROUND = 11'b000_0001_0000,
		ST_CVT   = 11'b000_0010_0000,
		ST_CRND  = 11'b000_0100_0000,
		ST_DSET  = 11'b000_1000_0000,
		ST_DIV   = 11'b001_0000_0000,
		ST_DFIN  = 11'b010_0000_0000,
		ST_DPACK = 11'b100_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic [4:0] step_q;

	assign sample_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd          = '0;
		state_d      = state_q;
		cmd.load     = (state_q == ST_IDLE) && sample_valid;
		case (state_q)
			ST_IDLE: begin
				if (sample_valid)
					state_d = ST_ALIGN;
			end
			ST_ALIGN: begin
				cmd.align = 1'b1;
				state_d   = ST_SUM;
			end
			ST_SUM: begin
				cmd.sum = 1'b1;
				state_d = ST_NORM;
			end
			ST_NORM: begin
				cmd.norm = 1'b1;
				state_d  = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.commit = 1'b1;
				state_d    = stat.last ? ST_CVT : ST_IDLE;
			end
			ST_CVT: begin
				cmd.cvt = 1'b1;
				state_d = ST_CRND;
			end
			ST_CRND: begin
				cmd.crnd = 1'b1;
				state_d  = ST_DSET;
			end
			ST_DSET: begin
				cmd.dset = 1'b1;
				state_d  = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == 5'(nsfm_pkg::DIV_STEPS - 1))
					state_d = ST_DFIN;
			end
			ST_DFIN: begin
				cmd.dfin = 1'b1;
				state_d  = ST_DPACK;
			end
			ST_DPACK: begin
				if (!stat.out_full) begin
					cmd.dpack = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				step_q <= step_q + 5'd1;
			else
				step_q <= '0;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/nsfm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nsfm_dp
// float accumulator, count converter, bit-serial divider and result register
// ----------------------------------------------------------------------------
module nsfm_dp #(
	parameter int COUNT_WIDTH = nsfm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire nsfm_pkg::sample_t sample,
	input  wire nsfm_pkg::cmd_t   cmd,
	output nsfm_pkg::stat_t       stat,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output nsfm_pkg::result_t     result
);

	localparam int EW = nsfm_pkg::EXT_W;

	// accumulator state
	logic [31:0]            sum_q;
	logic [COUNT_WIDTH-1:0] count_q;
	logic [31:0]            x_q;
	logic                   last_q;

	// adder working registers
	logic [EW-1:0] ml_q, ms_q, ext_q;
	logic [7:0]    el_q, expf_q;
	logic          sign_q, sub_q, zsign_q, spec_q, skip_q, zero_q, ovf_q;
	logic [31:0]   spec_val_q;
	logic [EW:0]   s_q;

	// divider working registers
	logic [31:0]       nc_q;
	logic [5:0]        pc_q;
	logic [23:0]       ma_q, mc_q;
	logic signed [9:0] ea_q, er_q;
	logic [24:0]       rem_q;
	logic [25:0]       quo_q;
	logic [EW-1:0]     dext_q;
	logic [7:0]        dexp_q;

	logic                  res_valid_q;
	nsfm_pkg::result_t     res_q;

	assign result_valid  = res_valid_q;
	assign result        = res_q;
	assign stat.last     = last_q;
	assign stat.out_full = res_valid_q & result_stall;

	// align: larger magnitude first, smaller shifted down
	logic        a_ge;
	logic [31:0] lg, sm;
	logic [7:0]  el, es, dexp;
	logic [4:0]  amt;
	logic        a_nan, a_inf, b_inf;

	always_comb begin
		a_ge  = sum_q[30:0] >= x_q[30:0];
		lg    = a_ge ? sum_q : x_q;
		sm    = a_ge ? x_q : sum_q;
		el    = (lg[30:23] == 8'd0) ? 8'd1 : lg[30:23];
		es    = (sm[30:23] == 8'd0) ? 8'd1 : sm[30:23];
		dexp  = el - es;
		amt   = (dexp > 8'd27) ? 5'd27 : dexp[4:0];
		a_nan = nsfm_pkg::is_nan(sum_q);
		a_inf = sum_q[30:0] == nsfm_pkg::INF_MAG;
		b_inf = x_q[30:0] == nsfm_pkg::INF_MAG;
	end

	// normalize after add
	logic [4:0]    lz;
	logic [7:0]    lim, sh8;
	logic [EW-1:0] next_ext;
	logic [8:0]    next_e;

	always_comb begin
		lz  = nsfm_pkg::lzc27(s_q[EW-1:0]);
		lim = el_q - 8'd1;
		sh8 = ({3'd0, lz} < lim) ? {3'd0, lz} : lim;
		if (s_q[EW]) begin
			next_ext = {s_q[EW:2], s_q[1] | s_q[0]};
			next_e   = {1'b0, el_q} + 9'd1;
		end else begin
			next_ext = s_q[EW-1:0] << sh8[4:0];
			next_e   = {1'b0, el_q} - {1'b0, sh8};
		end
	end

	logic [31:0] add_res;
	always_comb begin
		if (spec_q)
			add_res = spec_val_q;
		else if (zero_q)
			add_res = {zsign_q, 31'd0};
		else if (ovf_q)
			add_res = {sign_q, nsfm_pkg::INF_MAG};
		else
			add_res = nsfm_pkg::round_pack(sign_q, ext_q, expf_q);
	end

	// count and sum unpacking for the divide
	logic [31:0] cnt32;
	logic [4:0]  clz, slz;
	logic [23:0] smant;
	logic [23:0] cmant;
	logic        cinc;
	logic [24:0] cm25;
	logic        lt;
	logic [24:0] rdiff;
	logic        ge;
	logic signed [9:0] bexp;
	logic [5:0]  damt;

	always_comb begin
		cnt32 = 32'(count_q);
		clz   = nsfm_pkg::lzc32(cnt32);
		smant = {1'b0, sum_q[22:0]};
		slz   = nsfm_pkg::lzc24(smant);
		cmant = nc_q[31:8];
		cinc  = nc_q[7] & ((|nc_q[6:0]) | cmant[0]);
		cm25  = {1'b0, cmant} + {24'd0, cinc};
		lt    = ma_q < mc_q;
		ge    = rem_q >= {1'b0, mc_q};
		rdiff = ge ? (rem_q - {1'b0, mc_q}) : rem_q;
		bexp  = er_q + 10'sd127;
		damt  = 6'(10'sd1 - bexp);
	end

	logic        div_special;
	logic [31:0] div_res;
	always_comb begin
		div_special = 1'b1;
		if ((count_q == '0) || nsfm_pkg::is_nan(sum_q))
			div_res = nsfm_pkg::QNAN;
		else if (sum_q[30:0] == nsfm_pkg::INF_MAG)
			div_res = sum_q;
		else if (sum_q[30:0] == 31'd0)
			div_res = sum_q;
		else begin
			div_special = 1'b0;
			div_res     = nsfm_pkg::round_pack(sum_q[31], dext_q, dexp_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cmd.commit && !skip_q) begin
				sum_q <= add_res;
				if (count_q != '1)
					count_q <= count_q + COUNT_WIDTH'(1);
			end
			if (cmd.dpack) begin
				sum_q       <= '0;
				count_q     <= '0;
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= sample.value_bits;
			last_q <= sample.end_of_set;
		end
		if (cmd.align) begin
			ml_q       <= {|lg[30:23], lg[22:0], 3'd0};
			ms_q       <= nsfm_pkg::shr_sticky({|sm[30:23], sm[22:0], 3'd0}, amt);
			el_q       <= el;
			sign_q     <= lg[31];
			sub_q      <= sum_q[31] ^ x_q[31];
			zsign_q    <= sum_q[31] & x_q[31];
			skip_q     <= nsfm_pkg::is_nan(x_q);
			spec_q     <= a_nan | a_inf | b_inf;
			spec_val_q <= (a_nan || (a_inf && b_inf && (sum_q[31] != x_q[31]))) ?
				nsfm_pkg::QNAN : (a_inf ? sum_q : x_q);
		end
		if (cmd.sum)
			s_q <= sub_q ? ({1'b0, ml_q} - {1'b0, ms_q}) : ({1'b0, ml_q} + {1'b0, ms_q});
		if (cmd.norm) begin
			ext_q  <= next_ext;
			zero_q <= (s_q == '0);
			ovf_q  <= next_e >= 9'd255;
			expf_q <= next_ext[EW-1] ? next_e[7:0] : 8'd0;
		end
		if (cmd.cvt) begin
			nc_q <= cnt32 << clz;
			pc_q <= 6'd31 - {1'b0, clz};
			if (sum_q[30:23] == 8'd0) begin
				ma_q <= smant << slz;
				ea_q <= -10'sd126 - $signed({5'd0, slz});
			end else begin
				ma_q <= {1'b1, sum_q[22:0]};
				ea_q <= $signed({2'd0, sum_q[30:23]}) - 10'sd127;
			end
		end
		if (cmd.crnd) begin
			if (cm25[24]) begin
				mc_q <= 24'h800000;
				pc_q <= pc_q + 6'd1;
			end else begin
				mc_q <= cm25[23:0];
			end
		end
		if (cmd.dset) begin
			rem_q <= lt ? {ma_q, 1'b0} : {1'b0, ma_q};
			er_q  <= ea_q - $signed({4'd0, pc_q}) - $signed({9'd0, lt});
			quo_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q <= {rdiff[23:0], 1'b0};
			quo_q <= {quo_q[24:0], ge};
		end
		if (cmd.dfin) begin
			if (bexp > 10'sd0) begin
				dext_q <= {quo_q, |rem_q};
				dexp_q <= bexp[7:0];
			end else begin
				dext_q <= nsfm_pkg::shr_sticky({quo_q, |rem_q},
					(damt > 6'd27) ? 5'd27 : damt[4:0]);
				dexp_q <= 8'd0;
			end
		end
		if (cmd.dpack) begin
			res_q.mean_bits   <= (div_special || !nsfm_pkg::is_nan(div_res)) ?
				div_res : nsfm_pkg::QNAN;
			res_q.valid_count <= cnt32[nsfm_pkg::VCOUNT_W-1:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/nan_skipping_float_mean_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nan_skipping_float_mean_core
// nan-skipping mean of binary32 samples, one result per set
// ----------------------------------------------------------------------------
// Each sample item passes through accept, align, add, normalize and round on
// the single shared float adder; NaN samples pass through the same steps and
// leave sum and count untouched. The item flagged end_of_set then goes on
// through count conversion, divide setup, a bit-serial restoring divider
// producing one quotient bit per cycle, then finish and pack.
// The pack step waits for as long as the previous mean is still held and
// stalled in the output register, and the input stays stalled meanwhile.
// The result sits in an output register, so a new set can start while the
// previous mean still waits to be taken. An empty or NaN set yields 7FC00000.
// ----------------------------------------------------------------------------
module nan_skipping_float_mean_core #(
	parameter int COUNT_WIDTH = nsfm_pkg::COUNT_WIDTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// sample channel
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire nsfm_pkg::sample_t sample,
	// result channel
	output logic                   result_valid,
	input  wire logic              result_stall,
	output nsfm_pkg::result_t      result
);

	// controller to datapath commands and status back
	nsfm_pkg::cmd_t  cmd;
	nsfm_pkg::stat_t stat;

	nsfm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.stat         (stat),
		.cmd          (cmd)
	);

	nsfm_dp #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cmd          (cmd),
		.stat         (stat),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the nan-skipping binary32 mean core: a directed
// table of corner samples, then random sets; results are checked against
// typed table rows or a bit-exact software mean, double rounded to binary32
// ----------------------------------------------------------------------------
module testbench;

	localparam int          N_RANDOM  = 1230;
	localparam logic [31:0] ONE_BITS  = 32'h3F800000;
	localparam logic [23:0] CNT_MAX   = 24'hFFFFFF;

	logic              clk;
	logic              arst_n;
	logic              sample_valid;
	logic              sample_stall;
	nsfm_pkg::sample_t sample;
	logic              result_valid;
	logic              result_stall;
	nsfm_pkg::result_t result;

	// running state of the software mean
	logic [31:0]       acc_sum;
	logic [23:0]       acc_cnt;
	nsfm_pkg::result_t mean_q[$];

	int  n_err;
	int  hold_cycles;
	bit  stim_done;

	typedef struct {
		logic [31:0] value;
		logic        last;
		bit          typed;
		logic [31:0] mean;
		logic [23:0] cnt;
	} row_t;

	row_t dir_tab[] = '{
		'{32'h3F800000, 1'b1, 1, 32'h3F800000,   24'd1},  // plain one
		'{32'h7FC00000, 1'b1, 1, nsfm_pkg::QNAN, 24'd0},  // empty set
		'{32'hFFFFFFFF, 1'b1, 1, nsfm_pkg::QNAN, 24'd0},  // negative nan only
		'{32'h7F800001, 1'b0, 0, '0,             '0},     // signaling nan skipped
		'{32'h40000000, 1'b1, 1, 32'h40000000,   24'd1},
		'{32'h7F800000, 1'b0, 0, '0,             '0},     // opposite infinities
		'{32'hFF800000, 1'b1, 1, nsfm_pkg::QNAN, 24'd2},
		'{32'h7F7FFFFF, 1'b0, 0, '0,             '0},     // overflow to inf
		'{32'h7F7FFFFF, 1'b1, 1, 32'h7F800000,   24'd2},
		'{32'h00000001, 1'b1, 1, 32'h00000001,   24'd1},  // smallest subnormal
		'{32'h80000000, 1'b1, 1, 32'h00000000,   24'd1},  // negative zero onto +0
		'{32'h40400000, 1'b0, 0, '0,             '0},     // nan on the last item
		'{32'h7FC00000, 1'b1, 1, 32'h40400000,   24'd1},
		'{32'h3F800000, 1'b0, 0, '0,             '0},
		'{32'h40000000, 1'b1, 1, 32'h3FC00000,   24'd2},
		'{32'h807FFFFF, 1'b0, 0, '0,             '0},     // subnormals cancel
		'{32'h007FFFFF, 1'b1, 0, '0,             '0},
		'{32'hFF7FFFFF, 1'b1, 1, 32'hFF7FFFFF,   24'd1},
		'{32'h3DCCCCCD, 1'b0, 0, '0,             '0},     // rounding in sum and divide
		'{32'h3E4CCCCD, 1'b0, 0, '0,             '0},
		'{32'h3E99999A, 1'b1, 0, '0,             '0}
	};

	nan_skipping_float_mean_core i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample      (sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	function automatic bit nan_bits(input logic [31:0] b);
		return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
	endfunction

	// binary32 pattern to real, exact; NaN patterns come out as infinity
	function automatic real f32_to_real(input logic [31:0] b);
		real mag;
		if (b[30:23] == 8'hFF)
			return $bitstoreal({b[31], 11'h7FF, 52'd0});
		if (b[30:23] == 8'h00) begin
			if (b[22:0] == 23'd0)
				return $bitstoreal({b[31], 63'd0});
			mag = real'(b[22:0]) * (2.0 ** (-149));
			return b[31] ? -mag : mag;
		end
		return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'd0});
	endfunction

	// real to binary32, round to nearest even, subnormals kept; a single
	// binary32 add or divide done in double then rounded here is exact
	function automatic logic [31:0] real_to_f32(input real v);
		logic [63:0] d;
		logic [63:0] sig;
		logic [63:0] mant;
		logic [63:0] rem;
		logic [63:0] half;
		int          fe;
		int          sh;
		d = $realtobits(v);
		if (d[62:52] == 11'h7FF)
			return (d[51:0] != 0) ? nsfm_pkg::QNAN : {d[63], nsfm_pkg::INF_MAG};
		if (d[62:52] == 11'd0)
			return {d[63], 31'd0};
		sig = {11'd0, 1'b1, d[51:0]};
		fe  = int'(d[62:52]) - 1023 + 127;
		sh  = (fe >= 1) ? 29 : 29 + 1 - fe;
		if (sh > 60)
			sh = 60;
		mant = sig >> sh;
		rem  = sig & ((64'd1 << sh) - 1);
		half = 64'd1 << (sh - 1);
		if (rem > half || (rem == half && mant[0]))
			mant = mant + 1;
		if (fe < 1)
			return {d[63], mant[30:0]};
		if (mant[24]) begin
			mant = mant >> 1;
			fe   = fe + 1;
		end
		if (fe >= 255)
			return {d[63], nsfm_pkg::INF_MAG};
		return {d[63], 8'(fe), mant[22:0]};
	endfunction

	// fold one accepted sample into the running mean
	task automatic absorb_sample(input nsfm_pkg::sample_t s, output bit emit,
			output nsfm_pkg::result_t r);
		logic [31:0] q;
		emit = 1'b0;
		r    = '0;
		if (!nan_bits(s.value_bits)) begin
			if (nan_bits(acc_sum))
				acc_sum = nsfm_pkg::QNAN;
			else begin
				acc_sum = real_to_f32(f32_to_real(acc_sum) + f32_to_real(s.value_bits));
				if (nan_bits(acc_sum))
					acc_sum = nsfm_pkg::QNAN;
			end
			if (acc_cnt < CNT_MAX)
				acc_cnt = acc_cnt + 24'd1;
		end
		if (s.end_of_set) begin
			if (acc_cnt == 0 || nan_bits(acc_sum))
				q = nsfm_pkg::QNAN;
			else begin
				// count fits binary32 exactly at this width
				q = real_to_f32(f32_to_real(acc_sum) / real'(acc_cnt));
				if (nan_bits(q))
					q = nsfm_pkg::QNAN;
			end
			emit          = 1'b1;
			r.mean_bits   = q;
			r.valid_count = acc_cnt;
			acc_sum       = '0;
			acc_cnt       = '0;
		end
	endtask

	// offer one item and hold it until taken, then predict
	task automatic offer(input nsfm_pkg::sample_t s, input bit typed,
			input nsfm_pkg::result_t typed_r);
		bit                emit;
		nsfm_pkg::result_t r;
		sample       <= s;
		sample_valid <= 1'b1;
		do
			@(posedge clk);
		while (sample_stall);
		absorb_sample(s, emit, r);
		if (emit)
			mean_q.push_back(typed ? typed_r : r);
	endtask

	// idle gap between bursts
	task automatic pause_sender(input int n);
		if (n > 0) begin
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		v = $urandom;
		case ($urandom_range(0, 11))
			0, 1:    v = v;                                                 // raw pattern
			2:       v = {v[31], 8'hFF, (v[22:0] == 0) ? 23'd1 : v[22:0]};  // nan
			3:       v = {v[31], nsfm_pkg::INF_MAG};
			4:       v = {v[31], 31'd0};
			5:       v = {v[31], 8'h00, v[22:0]};                           // subnormal
			6:       v = {v[31], 8'(8'd250 + $urandom_range(0, 4)), v[22:0]}; // near max
			default: v = {v[31], 8'(8'd120 + $urandom_range(0, 15)), v[22:0]};
		endcase
		return v;
	endfunction

	// sender: directed table, then random sets in bursts and gaps
	initial begin
		nsfm_pkg::sample_t s;
		nsfm_pkg::result_t tr;
		int                sent;
		int                set_len;
		int                burst;
		arst_n       = 1'b0;
		sample_valid = 1'b0;
		sample       = '0;
		hold_cycles  = 0;
		stim_done    = 1'b0;
		acc_sum      = '0;
		acc_cnt      = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			s.value_bits   = dir_tab[i].value;
			s.end_of_set   = dir_tab[i].last;
			tr.mean_bits   = dir_tab[i].mean;
			tr.valid_count = dir_tab[i].cnt;
			offer(s, dir_tab[i].typed, tr);
			if ($urandom_range(0, 2) == 0)
				pause_sender($urandom_range(1, 4));
		end

		sent  = 0;
		burst = $urandom_range(1, 30);
		while (sent < N_RANDOM) begin
			// mostly short sets, now and then a long one
			set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
			                                      : $urandom_range(1, 6);
			for (int k = 0; k < set_len; k++) begin
				s.value_bits = rand_value();
				s.end_of_set = (k == set_len - 1);
				if (sent == 400)
					hold_cycles = 600;  // receiver holds off, block backs up
				if (sent == 800) begin
					// drain completely before going on
					sample_valid <= 1'b0;
					while (mean_q.size() != 0)
						@(posedge clk);
				end
				offer(s, 1'b0, tr);
				sent++;
				burst--;
				if (burst <= 0) begin
					pause_sender(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40)
					                                         : $urandom_range(0, 6));
					burst = $urandom_range(1, 30);
				end
			end
		end
		sample_valid <= 1'b0;
		stim_done = 1'b1;
	end

	// receiver: stall pattern that steps through four modes in turn
	always @(posedge clk or negedge arst_n) begin
		int unsigned cyc;
		if (!arst_n) begin
			result_stall <= 1'b0;
			cyc = 0;
		end else begin
			cyc++;
			if (hold_cycles > 0) begin
				result_stall <= 1'b1;
				hold_cycles = hold_cycles - 1;
			end else begin
				case ((cyc >> 6) % 4)
					0:       result_stall <= 1'b0;
					1:       result_stall <= ($urandom_range(0, 1) == 0);
					2:       result_stall <= ($urandom_range(0, 7) != 0);
					default: result_stall <= ((cyc % 5) < 2);
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		nsfm_pkg::result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (mean_q.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("unexpected result mean=%h count=%0d", result.mean_bits,
						result.valid_count);
			end else begin
				want = mean_q.pop_front();
				if (result.mean_bits !== want.mean_bits
						|| result.valid_count !== want.valid_count) begin
					n_err++;
					if (n_err <= 10)
						$display("mismatch: mean exp %h got %h, count exp %0d got %0d",
							want.mean_bits, result.mean_bits, want.valid_count,
							result.valid_count);
				end
			end
		end
	end

	// end of run
	initial begin
		n_err = 0;
		wait (stim_done);
		while (mean_q.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (n_err == 0 && mean_q.size() == 0)
			$display("PASS nan_skipping_float_mean_core");
		else
			$display("FAIL nan_skipping_float_mean_core");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("FAIL nan_skipping_float_mean_core");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/nsfm_pkg.sv
rtl/core/nsfm_ctrl.sv
rtl/core/nsfm_dp.sv
rtl/core/nan_skipping_float_mean_core.sv
bench/testbench.sv
